// ===== rtl/ccc_pkg.sv =====
// Shared types and constants for the cooling cycle controller.
// Holds the beat payload structs, the automation phase enum and the code values.
// No dependencies.
package ccc_pkg;

    // One timestamped sample beat.
    typedef struct packed {
        logic        [31:0] now_ms;
        logic        [1:0]  run_mode;
        logic signed [11:0] liquid_temp;
        logic signed [11:0] outside_temp;
    } ccc_in_t;

    // One actuator result beat.
    typedef struct packed {
        logic [7:0] pump_duty;
        logic       fan_enable;
        logic [2:0] status_code;
        logic [1:0] event_code;
    } ccc_out_t;

    // Automation phase, used as the state of the automatic mode.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PUMP = 2'd1,
        PH_FAN  = 2'd2,
        PH_COOL = 2'd3
    } ccc_phase_t;

    // Operating modes; the unused fourth code behaves as manual.
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_AUTO = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_INVALID = 3'd0;
    localparam logic [2:0] ST_SAFETY  = 3'd1;
    localparam logic [2:0] ST_OFF     = 3'd2;
    localparam logic [2:0] ST_MANUAL  = 3'd3;
    localparam logic [2:0] ST_IDLE    = 3'd4;
    localparam logic [2:0] ST_PUMP    = 3'd5;
    localparam logic [2:0] ST_FAN     = 3'd6;
    localparam logic [2:0] ST_COOL    = 3'd7;

    // Cycle end event codes.
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_REACHED = 2'd1;
    localparam logic [1:0] EV_TIMEOUT = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_TARGET    = 3'd0;
    localparam logic [2:0] REG_SAFETY    = 3'd1;
    localparam logic [2:0] REG_FAN_OFS   = 3'd2;
    localparam logic [2:0] REG_BOOST     = 3'd3;
    localparam logic [2:0] REG_IDLE_RUN  = 3'd4;
    localparam logic [2:0] REG_IDLE_REST = 3'd5;
    localparam logic [2:0] REG_CYCLE_MAX = 3'd6;
    localparam logic [2:0] REG_COOLDOWN  = 3'd7;

    // Fixed timing and level constants.
    localparam logic [31:0] IDLE_MAX_MS      = 32'd600000;
    localparam logic [31:0] FAN_MIN_DELAY_MS = 32'd30000;
    localparam logic [7:0]  IDLE_DUTY        = 8'd204;
    localparam logic [6:0]  BASE_PWM         = 7'd77;

    // Temperatures in signed 1/16 degC.
    localparam logic signed [11:0] LIQ_LOW    = -12'sd1600;
    localparam logic signed [11:0] LIQ_HIGH   = 12'sd2000;
    localparam logic signed [12:0] COOL_FLOOR = -13'sd32;
    localparam logic signed [12:0] EXT_BELOW  = 13'sd80;

    // Pump duty bands and limits.
    localparam logic signed [13:0] BAND_HIGH = 14'sd48;
    localparam logic signed [13:0] BAND_MID  = 14'sd24;
    localparam logic signed [13:0] BAND_LOW  = 14'sd8;
    localparam logic signed [7:0]  ADJ_HIGH  = 8'sd50;
    localparam logic signed [7:0]  ADJ_MID   = 8'sd25;
    localparam logic signed [7:0]  ADJ_LOW   = -8'sd25;
    localparam logic signed [7:0]  ADJ_COLD  = -8'sd20;
    localparam logic signed [7:0]  ADJ_WARM  = 8'sd30;
    localparam logic signed [10:0] PWM_MIN   = 11'sd50;
    localparam logic signed [10:0] PWM_MAX   = 11'sd200;

endpackage

// ===== rtl/cooling_cycle_controller.sv =====
// Cooling cycle controller: one pump/fan result beat for every sample beat.
// Path: a sample beat is accepted into the hold register, and its result beat is then
// registered in the result register, where it waits until it is taken downstream.
// Throughput: one sample per cycle unless results stall; the single-pass decision logic sits
// between the two registers; a sample enters an empty hold register while a result waits downstream.
// Reset (rst_n, asynchronous, active low) empties both registers, parks the automation in
// idle with no start stamps, and loads the configuration registers with their default values.
module cooling_cycle_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  ccc_pkg::ccc_in_t  sample,
    output logic              result_valid,
    input  logic              result_stall,
    output ccc_pkg::ccc_out_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import ccc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken: the user must use
    // the port only while the block is quiet, as no interlock enforces it.
    // ------------------------------------------------------------------
    logic signed [11:0] target_temp_reg;
    logic signed [11:0] safety_temp_reg;
    logic        [9:0]  fan_offset_reg;
    logic        [5:0]  boost_gain_reg;
    logic        [31:0] idle_run_ms_reg;
    logic        [31:0] idle_rest_ms_reg;
    logic        [31:0] cycle_max_ms_reg;
    logic        [31:0] cooldown_ms_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_temp_reg  <= 12'sd80;
            safety_temp_reg  <= 12'sd160;
            fan_offset_reg   <= 10'd40;
            boost_gain_reg   <= 6'd16;
            idle_run_ms_reg  <= 32'd40000;
            idle_rest_ms_reg <= 32'd20000;
            cycle_max_ms_reg <= 32'd300000;
            cooldown_ms_reg  <= 32'd120000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TARGET:    target_temp_reg  <= $signed(cfg_data[11:0]);
                REG_SAFETY:    safety_temp_reg  <= $signed(cfg_data[11:0]);
                REG_FAN_OFS:   fan_offset_reg   <= cfg_data[9:0];
                REG_BOOST:     boost_gain_reg   <= cfg_data[5:0];
                REG_IDLE_RUN:  idle_run_ms_reg  <= cfg_data;
                REG_IDLE_REST: idle_rest_ms_reg <= cfg_data;
                REG_CYCLE_MAX: cycle_max_ms_reg <= cfg_data;
                REG_COOLDOWN:  cooldown_ms_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Beat flow. A sample beat lands in the hold register. It is processed
    // in the cycle in which the result register can take a new value: the
    // result register is empty or its beat is being taken at the same edge.
    // At that edge the automation state is updated as well, so state and
    // results advance together, one sample at a time.
    // ------------------------------------------------------------------
    ccc_in_t  hold_reg;
    logic     hold_valid_reg;
    ccc_out_t result_reg;
    ccc_out_t result_next;
    logic     result_valid_reg;
    logic     advance;

    assign advance      = hold_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = hold_valid_reg && !advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                hold_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
        begin
            hold_reg <= sample;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------
    // Automation state. A start stamp of zero means "not started", so a
    // sample taken at time zero can leave a stamp that later reads as unset.
    // ------------------------------------------------------------------
    ccc_phase_t  phase_reg,            phase_next;
    logic [31:0] phase_start_reg,      phase_start_next;
    logic [31:0] burst_start_reg,      burst_start_next;
    logic        idle_pump_on_reg,     idle_pump_on_next;
    logic        fan_cycle_active_reg, fan_cycle_active_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_IDLE;
            phase_start_reg      <= '0;
            burst_start_reg      <= '0;
            idle_pump_on_reg     <= 1'b0;
            fan_cycle_active_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg            <= phase_next;
            phase_start_reg      <= phase_start_next;
            burst_start_reg      <= burst_start_next;
            idle_pump_on_reg     <= idle_pump_on_next;
            fan_cycle_active_reg <= fan_cycle_active_next;
        end
    end

    // ------------------------------------------------------------------
    // Shared decisions for the held sample.
    // ------------------------------------------------------------------
    logic [31:0]        now;
    logic signed [11:0] liq;
    logic signed [11:0] ext;
    logic               reading_ok;
    logic               over_safety;
    logic               auto_mode;

    assign now         = hold_reg.now_ms;
    assign liq         = hold_reg.liquid_temp;
    assign ext         = hold_reg.outside_temp;
    assign reading_ok  = (liq > LIQ_LOW) && (liq < LIQ_HIGH);
    assign over_safety = liq > safety_temp_reg;
    assign auto_mode   = hold_reg.run_mode == MODE_AUTO;

    // Cooling target, lowered by the boost and never below -2 degC.
    logic signed [12:0] cool_raw;
    logic signed [12:0] cool_target;
    logic               reached;

    assign cool_raw    = {target_temp_reg[11], target_temp_reg}
                         - $signed({7'b0, boost_gain_reg});
    assign cool_target = (cool_raw < COOL_FLOOR) ? COOL_FLOOR : cool_raw;
    assign reached     = $signed({liq[11], liq}) <= cool_target;

    // Phase progress in automatic mode. The fan trigger is applied first; an
    // idle phase that has to leave drops into the pump phase in the same step.
    logic               start_unset;
    logic [31:0]        start_eff;
    logic signed [12:0] fan_threshold;
    logic               fan_trigger;
    ccc_phase_t         phase_trig;
    logic               idle_exit;
    ccc_phase_t         phase_work;
    logic [31:0]        start_work;
    logic [31:0]        elapsed_work;
    logic               cycle_done;
    logic               cooldown_done;

    assign start_unset   = phase_start_reg == '0;
    assign start_eff     = start_unset ? now : phase_start_reg;
    assign fan_threshold = {target_temp_reg[11], target_temp_reg}
                           + $signed({3'b000, fan_offset_reg});
    assign fan_trigger   = ($signed({liq[11], liq}) > fan_threshold)
                           && ((now - start_eff) > FAN_MIN_DELAY_MS)
                           && !fan_cycle_active_reg
                           && (phase_reg != PH_FAN);
    assign phase_trig    = fan_trigger ? PH_FAN : phase_reg;
    assign idle_exit     = (phase_trig == PH_IDLE)
                           && ((liq > target_temp_reg)
                               || ((now - start_eff) >= IDLE_MAX_MS));
    assign phase_work    = idle_exit ? PH_PUMP : phase_trig;
    assign start_work    = (fan_trigger || idle_exit) ? now : start_eff;
    assign elapsed_work  = now - start_work;
    assign cycle_done    = reached || (elapsed_work >= cycle_max_ms_reg);
    assign cooldown_done = elapsed_work >= cooldown_ms_reg;

    // Idle duty-cycling: a burst of pump running then a rest, alternating.
    logic        burst_unset;
    logic [31:0] burst_eff;
    logic        pump_on_eff;
    logic [31:0] burst_elapsed;
    logic [31:0] burst_new;
    logic        pump_on_new;

    assign burst_unset   = burst_start_reg == '0;
    assign burst_eff     = burst_unset ? now : burst_start_reg;
    assign pump_on_eff   = burst_unset || idle_pump_on_reg;
    assign burst_elapsed = now - burst_eff;

    always_comb
    begin
        burst_new   = burst_eff;
        pump_on_new = pump_on_eff;
        if (pump_on_eff)
        begin
            if (burst_elapsed >= idle_run_ms_reg)
            begin
                pump_on_new = 1'b0;
                burst_new   = now;
            end
        end
        else if (burst_elapsed >= idle_rest_ms_reg)
        begin
            pump_on_new = 1'b1;
            burst_new   = now;
        end
    end

    // Pump duty during a pump cycle: boost base plus band and ambient terms,
    // then clamped to the working range.
    logic signed [13:0] temp_gap;
    logic signed [12:0] ext_cold_limit;
    logic signed [7:0]  band_adj;
    logic signed [7:0]  ext_adj;
    logic        [12:0] base_product;
    logic signed [10:0] pwm_sum;
    logic        [7:0]  pump_pwm;

    assign temp_gap       = {{2{liq[11]}}, liq} - {cool_target[12], cool_target};
    assign ext_cold_limit = {target_temp_reg[11], target_temp_reg} - EXT_BELOW;
    assign base_product   = BASE_PWM * {7'b0, boost_gain_reg};

    always_comb
    begin
        priority if (temp_gap > BAND_HIGH)
            band_adj = ADJ_HIGH;
        else if (temp_gap > BAND_MID)
            band_adj = ADJ_MID;
        else if (temp_gap < BAND_LOW)
            band_adj = ADJ_LOW;
        else
            band_adj = '0;

        priority if ($signed({ext[11], ext}) < ext_cold_limit)
            ext_adj = ADJ_COLD;
        else if (ext > target_temp_reg)
            ext_adj = ADJ_WARM;
        else
            ext_adj = '0;
    end

    assign pwm_sum = $signed({2'b00, base_product[12:4]})
                     + {{3{band_adj[7]}}, band_adj}
                     + {{3{ext_adj[7]}}, ext_adj};

    always_comb
    begin
        priority if (pwm_sum < PWM_MIN)
            pump_pwm = PWM_MIN[7:0];
        else if (pwm_sum > PWM_MAX)
            pump_pwm = PWM_MAX[7:0];
        else
            pump_pwm = pwm_sum[7:0];
    end

    // ------------------------------------------------------------------
    // Next state. Invalid readings and the safety override leave the state
    // untouched; off and manual park the automation but keep the fan flag.
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next            = phase_reg;
        phase_start_next      = phase_start_reg;
        burst_start_next      = burst_start_reg;
        idle_pump_on_next     = idle_pump_on_reg;
        fan_cycle_active_next = fan_cycle_active_reg;

        if (reading_ok && !over_safety)
        begin
            if (!auto_mode)
            begin
                phase_next        = PH_IDLE;
                phase_start_next  = now;
                burst_start_next  = '0;
                idle_pump_on_next = 1'b0;
            end
            else
            begin
                phase_next            = phase_work;
                phase_start_next      = start_work;
                fan_cycle_active_next = fan_cycle_active_reg || fan_trigger;
                if (idle_exit)
                begin
                    burst_start_next  = '0;
                    idle_pump_on_next = 1'b0;
                end

                unique case (phase_work)
                    PH_IDLE:
                    begin
                        burst_start_next  = burst_new;
                        idle_pump_on_next = pump_on_new;
                    end
                    PH_PUMP:
                    begin
                        if (cycle_done)
                        begin
                            phase_next        = PH_COOL;
                            phase_start_next  = now;
                            burst_start_next  = '0;
                            idle_pump_on_next = 1'b0;
                        end
                    end
                    PH_FAN:
                    begin
                        if (cycle_done)
                        begin
                            phase_next            = PH_COOL;
                            phase_start_next      = now;
                            fan_cycle_active_next = 1'b0;
                        end
                    end
                    PH_COOL:
                    begin
                        if (cooldown_done)
                        begin
                            phase_next        = PH_IDLE;
                            phase_start_next  = now;
                            burst_start_next  = '0;
                            idle_pump_on_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result beat for the held sample.
    // ------------------------------------------------------------------
    always_comb
    begin
        result_next = '{pump_duty: '0, fan_enable: 1'b0,
                        status_code: ST_INVALID, event_code: EV_NONE};

        priority if (!reading_ok)
        begin
            result_next.status_code = ST_INVALID;
        end
        else if (over_safety)
        begin
            result_next.fan_enable  = 1'b1;
            result_next.status_code = ST_SAFETY;
        end
        else if (!auto_mode)
        begin
            result_next.status_code = (hold_reg.run_mode == MODE_OFF) ? ST_OFF : ST_MANUAL;
        end
        else
        begin
            unique case (phase_work)
                PH_IDLE:
                begin
                    result_next.pump_duty   = pump_on_new ? IDLE_DUTY : '0;
                    result_next.status_code = ST_IDLE;
                end
                PH_PUMP:
                begin
                    if (cycle_done)
                    begin
                        result_next.status_code = ST_COOL;
                        result_next.event_code  = reached ? EV_REACHED : EV_TIMEOUT;
                    end
                    else
                    begin
                        result_next.pump_duty   = pump_pwm;
                        result_next.fan_enable  = 1'b1;
                        result_next.status_code = ST_PUMP;
                    end
                end
                PH_FAN:
                begin
                    result_next.fan_enable  = 1'b1;
                    result_next.status_code = ST_FAN;
                    if (cycle_done)
                    begin
                        result_next.event_code = reached ? EV_REACHED : EV_TIMEOUT;
                    end
                end
                PH_COOL:
                begin
                    result_next.status_code = ST_COOL;
                end
                default:
                begin
                    result_next.status_code = ST_INVALID;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    // The input side only stalls while a sample waits behind a blocked result.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (hold_valid_reg && result_valid && result_stall))
        else $error("sample stalled without a blocked result");

    // A new result appears only after a sample was held.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(hold_valid_reg))
        else $error("result beat without a held sample");

    // The automation state moves only when a sample is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(phase_reg) && $stable(phase_start_reg)
                      && $stable(fan_cycle_active_reg)))
        else $error("automation state changed without a sample");

endmodule
